// ----- rtl/mks_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mks_pkg
// Shared sizes and beat types for the matrix keypad scanner.
// ----------------------------------------------------------------------------
package mks_pkg;

    localparam int ROWS    = 4;
    localparam int COLS    = 4;
    localparam int BUTTONS = 4;

    localparam int KEYS      = ROWS * COLS;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int KEY_CODE_W = $clog2(KEYS + 1);
    localparam int INTERVAL_W = 16;
    localparam int INTERVAL_RESET = 20;

    typedef struct packed {
        logic               ms_tick;
        logic [COLS-1:0]    column_lines;
        logic [BUTTONS-1:0] button_lines;
    } mks_in_t;

    typedef struct packed {
        logic [ROWS-1:0]       row_drive;
        logic                  scan_done;
        logic [KEYS-1:0]       keys_down;
        logic [KEYS-1:0]       keys_just_pressed;
        logic [KEY_CODE_W-1:0] first_pressed_key;
        logic [BUTTONS-1:0]    buttons_just_pressed;
    } mks_out_t;

endpackage
`default_nettype wire

// ----- rtl/mks_prio.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mks_prio
// Lowest set bit of the just-pressed map as a one-based key code.
// ----------------------------------------------------------------------------
module mks_prio
    import mks_pkg::*;
(
    input  wire logic [KEYS-1:0]       just,
    output      logic [KEY_CODE_W-1:0] code
);

    always_comb
    begin
        code = '0;
        for (int k = KEYS - 1; k >= 0; k--)
        begin
            if (just[k])
            begin
                code = KEY_CODE_W'(k + 1);
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/mks_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mks_core
// Scan state: tick counter, row sequencer, key and button state registers.
// Updates on each accepted beat and presents the result of that beat.
// ----------------------------------------------------------------------------
module mks_core
    import mks_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire mks_in_t               in_beat,
    input  wire logic [INTERVAL_W-1:0] interval,
    output      mks_out_t              result
);

    logic [INTERVAL_W-1:0] elapsed_reg, elapsed_next, elapsed_inc;
    logic                  scanning_reg, scanning_next;
    logic [ROW_W-1:0]      row_index_reg, row_index_next;
    logic [KEYS-1:0]       key_now_reg, key_now_next;
    logic [KEYS-1:0]       key_before_reg, key_before_next;
    logic [BUTTONS-1:0]    button_now_reg, button_now_next;
    logic [BUTTONS-1:0]    button_before_reg, button_before_next;
    logic [ROWS-1:0]       row_drive;
    logic                  done;
    logic                  last_row;
    logic [KEYS-1:0]       just;
    logic [KEY_CODE_W-1:0] first_code;

    assign last_row = (row_index_reg == ROW_W'(ROWS - 1));

    always_comb
    begin
        elapsed_inc = elapsed_reg;
        if (in_beat.ms_tick && (elapsed_reg != {INTERVAL_W{1'b1}}))
        begin
            elapsed_inc = elapsed_reg + 1'b1;
        end

        elapsed_next       = elapsed_inc;
        scanning_next      = scanning_reg;
        row_index_next     = row_index_reg;
        key_now_next       = key_now_reg;
        key_before_next    = key_before_reg;
        button_now_next    = button_now_reg;
        button_before_next = button_before_reg;
        row_drive          = '0;
        done               = 1'b0;

        if (!scanning_reg)
        begin
            if (elapsed_inc >= interval)
            begin
                elapsed_next    = '0;
                key_before_next = key_now_reg;
                scanning_next   = 1'b1;
                row_index_next  = '0;
                row_drive       = ROWS'(1);
            end
        end
        else
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                if (row_index_reg == ROW_W'(r))
                begin
                    key_now_next[r*COLS +: COLS] = ~in_beat.column_lines;
                end
            end
            if (last_row)
            begin
                button_before_next = button_now_reg;
                button_now_next    = ~in_beat.button_lines;
                scanning_next      = 1'b0;
                row_index_next     = '0;
                done               = 1'b1;
            end
            else
            begin
                row_index_next = row_index_reg + 1'b1;
                row_drive      = ROWS'(1) << ({1'b0, row_index_reg} + 1'b1);
            end
        end
    end

    assign just = key_now_next & ~key_before_next;

    mks_prio u_prio (
        .just (just),
        .code (first_code)
    );

    always_comb
    begin
        result.row_drive            = row_drive;
        result.scan_done            = done;
        result.keys_down            = key_now_next;
        result.keys_just_pressed    = just;
        result.first_pressed_key    = first_code;
        result.buttons_just_pressed = button_now_next & ~button_before_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg       <= '0;
            scanning_reg      <= 1'b0;
            row_index_reg     <= '0;
            key_now_reg       <= '0;
            key_before_reg    <= '0;
            button_now_reg    <= '0;
            button_before_reg <= '0;
        end
        else if (step)
        begin
            elapsed_reg       <= elapsed_next;
            scanning_reg      <= scanning_next;
            row_index_reg     <= row_index_next;
            key_now_reg       <= key_now_next;
            key_before_reg    <= key_before_next;
            button_now_reg    <= button_now_next;
            button_before_reg <= button_before_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/matrix_keypad_scanner.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_keypad_scanner
// Rate-limited key matrix scanner with direct buttons, one result per beat.
// ----------------------------------------------------------------------------
//  channel   signals                         beat
//  in        in_valid/in_ready/in_data       one pin sample with ms tick
//  out       out_valid/out_ready/out_data    key and button report
//  cfg       cfg_write_en/cfg_write_data     scan interval in ms
//
//  one beat per cycle while in_ready is high; the result appears in the cycle
//  after its input beat, held in the output register.
//  in_ready is high whenever the output register is empty or being drained.
//  reset clears all key and button state and sets the interval to 20 ms.
//  a stalled output holds its beat and blocks new input only while full.
// ----------------------------------------------------------------------------
module matrix_keypad_scanner
    import mks_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output      logic                  in_ready,
    input  wire mks_in_t               in_data,
    output      logic                  out_valid,
    input  wire logic                  out_ready,
    output      mks_out_t              out_data,
    input  wire logic                  cfg_write_en,
    input  wire logic [INTERVAL_W-1:0] cfg_write_data
);

    logic [INTERVAL_W-1:0] interval_reg;
    logic                  out_valid_reg;
    mks_out_t              out_data_reg;
    mks_out_t              result;
    logic                  step;

    assign in_ready  = !out_valid_reg || out_ready;
    assign step      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    mks_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .in_beat  (in_data),
        .interval (interval_reg),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg  <= INTERVAL_W'(INTERVAL_RESET);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                interval_reg <= cfg_write_data;
            end
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= result;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/mks_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mks_checker
// Port-level checks on the keypad scanner output beats.
// ----------------------------------------------------------------------------
module mks_checker
    import mks_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     out_valid,
    input wire logic     out_ready,
    input wire mks_out_t out_data
);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.scan_done |-> out_data.row_drive == '0)
        else $error("row driven on scan_done beat");

    a_row_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0(out_data.row_drive))
        else $error("row_drive not one-hot");

    a_just_subset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.keys_just_pressed & ~out_data.keys_down) == '0)
        else $error("just-pressed key not down");

    a_first_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.first_pressed_key == '0)
                       == (out_data.keys_just_pressed == '0)))
        else $error("first key code disagrees with just-pressed map");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled output beat changed");

endmodule

bind matrix_keypad_scanner mks_checker u_mks_checker (.*);
`default_nettype wire
